// ===== rtl/ddgtp_pkg.sv =====
// ----------------------------------------------------------------------------
// ddgtp_pkg
// Shared types, constants and tables of the go-to-point wheel speed pipeline.
// ----------------------------------------------------------------------------
package ddgtp_pkg;

  localparam int unsigned CordicSteps = 16;

  localparam logic signed [15:0] PiQ13     = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [19:0] PiQ16     = 20'sd205887;
  localparam logic signed [17:0] TwoPiQ13  = 18'sd51472;
  localparam logic signed [17:0] Th95      = 18'sd13582;
  localparam logic signed [17:0] Th85      = 18'sd12153;
  localparam logic signed [17:0] Th40      = 18'sd5719;
  localparam logic [17:0]        NearQ12   = 18'd20480;

  localparam logic [14:0] LinGainRst = 15'd8192;
  localparam logic [14:0] AngGainRst = 15'd819;

  typedef enum logic [0:0] {
    REG_LIN_GAIN = 1'b0,
    REG_ANG_GAIN = 1'b1
  } reg_idx_e;

  // Stage-one results: deltas and bearing special cases.
  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [15:0] heading;
    logic signed [14:0] damping;
    logic               axis_hit;
    logic signed [15:0] axis_brg;
  } geo_t;

  // CORDIC lane state.
  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [20:0] z;
  } rot_t;

  function automatic logic signed [20:0] atan_lut(input logic [3:0] i);
    logic signed [20:0] r;
    unique case (i)
      4'd0:  r = 21'sd51472;
      4'd1:  r = 21'sd30386;
      4'd2:  r = 21'sd16055;
      4'd3:  r = 21'sd8150;
      4'd4:  r = 21'sd4091;
      4'd5:  r = 21'sd2047;
      4'd6:  r = 21'sd1024;
      4'd7:  r = 21'sd512;
      4'd8:  r = 21'sd256;
      4'd9:  r = 21'sd128;
      4'd10: r = 21'sd64;
      4'd11: r = 21'sd32;
      4'd12: r = 21'sd16;
      4'd13: r = 21'sd8;
      4'd14: r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] sig_lut(input logic [4:0] i);
    logic [16:0] r;
    unique case (i)
      5'd0:  r = 17'd32768;
      5'd1:  r = 17'd40793;
      5'd2:  r = 17'd47911;
      5'd3:  r = 17'd53581;
      5'd4:  r = 17'd57724;
      5'd5:  r = 17'd60565;
      5'd6:  r = 17'd62428;
      5'd7:  r = 17'd63615;
      5'd8:  r = 17'd64357;
      5'd9:  r = 17'd64816;
      5'd10: r = 17'd65097;
      5'd11: r = 17'd65269;
      5'd12: r = 17'd65374;
      5'd13: r = 17'd65438;
      5'd14: r = 17'd65476;
      5'd15: r = 17'd65500;
      default: r = 17'd65514;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/diff_drive_go_to_point_top.sv =====
// ----------------------------------------------------------------------------
// diff_drive_go_to_point_top
// Go-to-point wheel speed pipeline for a differential-drive robot.
// ----------------------------------------------------------------------------
// A pose enters every cycle while in_stall_o is low, and its wheel speeds leave
// after one delta stage, sixteen CORDIC steps (the square root runs beside
// them, two bits a stage), then wrap/band, multiply, product and rounding
// stages. The whole pipeline advances together and freezes while the output
// is stalled and full, so in_stall_o follows out_stall_i only when the output
// holds a beat.
module diff_drive_go_to_point_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [14:0] damping_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_speed_o,
  output logic signed [15:0] right_speed_o
);

  localparam int unsigned Depth = 21;

  logic [14:0] lin_gain, ang_gain;
  logic        adv;
  logic [Depth-1:0] vld_q;

  ddgtp_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .lin_gain_o(lin_gain), .ang_gain_o(ang_gain)
  );

  assign adv        = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Stage 1: deltas.
  ddgtp_pkg::geo_t geo_d, geo_q;
  ddgtp_pkg::rot_t rot0_d;
  logic [34:0] sq_d, sq0_q;
  logic signed [16:0] dx1, dy1;
  logic signed [27:0] xs, ys;

  always_comb begin
    dx1 = 17'(goal_x_i) - 17'(pos_x_i);
    dy1 = 17'(goal_y_i) - 17'(pos_y_i);
    geo_d.dx = dx1;
    geo_d.dy = dy1;
    geo_d.heading = heading_i;
    geo_d.damping = damping_i;
    geo_d.axis_hit = (dx1 == 17'sd0) || (dy1 == 17'sd0);
    if (dx1 == 17'sd0 && dy1 == 17'sd0) geo_d.axis_brg = 16'sd0;
    else if (dx1 == 17'sd0) geo_d.axis_brg = dy1 > 0 ? ddgtp_pkg::HalfPiQ13
                                                      : -ddgtp_pkg::HalfPiQ13;
    else if (dx1 > 0) geo_d.axis_brg = 16'sd0;
    else geo_d.axis_brg = ddgtp_pkg::PiQ13;
    xs = 28'(dx1) <<< 8;
    ys = 28'(dy1) <<< 8;
    rot0_d.x = xs;
    rot0_d.y = ys;
    rot0_d.z = 21'sd0;
    if (dx1 < 0) begin
      rot0_d.x = -xs;
      rot0_d.y = -ys;
      rot0_d.z = dy1 >= 0 ? 21'(ddgtp_pkg::PiQ16) : -21'(ddgtp_pkg::PiQ16);
    end
    sq_d = 35'(34'(dx1 * dx1)) + 35'(34'(dy1 * dy1));
  end

  ddgtp_pkg::rot_t rot0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      geo_q  <= geo_d;
      rot0_q <= rot0_d;
      sq0_q  <= sq_d;
    end
  end

  // Stages 2..17: CORDIC chain; square root over the first nine of them.
  ddgtp_pkg::rot_t rot_c [ddgtp_pkg::CordicSteps+1];
  ddgtp_pkg::geo_t geo_c [ddgtp_pkg::CordicSteps+1];
  logic [34:0] rem_c [10];
  logic [17:0] root_c [10];
  logic [17:0] de_dly [7];

  assign rot_c[0]  = rot0_q;
  assign geo_c[0]  = geo_q;
  assign rem_c[0]  = sq0_q;
  assign root_c[0] = '0;

  for (genvar i = 0; i < ddgtp_pkg::CordicSteps; i++) begin : g_cordic
    ddgtp_cordic_stage u_st (
      .clk_i, .step_i(4'(i)), .en_i(adv), .rot_i(rot_c[i]), .rot_o(rot_c[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) geo_c[i+1] <= geo_c[i];
    end
  end

  for (genvar j = 0; j < 9; j++) begin : g_sqrt
    ddgtp_isqrt_stage u_sq (
      .clk_i, .pos_i(5'(17 - 2*j)), .en_i(adv), .rem_i(rem_c[j]),
      .root_i(root_c[j]), .rem_o(rem_c[j+1]), .root_o(root_c[j+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      de_dly[0] <= root_c[9];
      for (int k = 1; k < 7; k++) de_dly[k] <= de_dly[k-1];
    end
  end

  // Stage 18: bearing, wrap, band, flip.
  logic signed [20:0] zr;
  logic signed [15:0] brg;
  logic signed [17:0] dth_a, dth_b;
  logic [12:0] k4_d;
  logic sgn_d, spin_d;
  logic signed [14:0] dth_d;
  ddgtp_pkg::geo_t g16;
  logic [17:0] de16;
  logic signed [17:0] adth;

  assign g16  = geo_c[ddgtp_pkg::CordicSteps];
  assign de16 = de_dly[6];

  always_comb begin
    zr = (rot_c[ddgtp_pkg::CordicSteps].z + 21'sd4) >>> 3;
    if (zr > 21'(ddgtp_pkg::PiQ13)) brg = ddgtp_pkg::PiQ13;
    else if (zr < -21'(ddgtp_pkg::PiQ13)) brg = -ddgtp_pkg::PiQ13;
    else brg = 16'(zr);
    if (g16.axis_hit) brg = g16.axis_brg;
    dth_a = 18'(brg) - 18'(g16.heading);
    if (dth_a > 18'(ddgtp_pkg::PiQ13)) dth_a = dth_a - ddgtp_pkg::TwoPiQ13;
    else if (dth_a < -18'(ddgtp_pkg::PiQ13)) dth_a = dth_a + ddgtp_pkg::TwoPiQ13;
    if (de16 > 18'd4096) k4_d = 13'd3095;
    else if (de16 > 18'd2048) k4_d = 13'd3459;
    else if (de16 > 18'd1228) k4_d = 13'd3823;
    else if (de16 > 18'd819) k4_d = 13'd4187;
    else k4_d = 13'd4551;
    sgn_d = 1'b0;
    dth_b = dth_a;
    if (dth_a > ddgtp_pkg::Th95) begin
      dth_b = dth_a - 18'(ddgtp_pkg::PiQ13);
      sgn_d = 1'b1;
    end else if (dth_a < -ddgtp_pkg::Th95) begin
      dth_b = dth_a + 18'(ddgtp_pkg::PiQ13);
      sgn_d = 1'b1;
    end
    adth   = dth_b < 0 ? -dth_b : dth_b;
    spin_d = adth > ddgtp_pkg::Th85;
    if (de16 < ddgtp_pkg::NearQ12 && adth <= ddgtp_pkg::Th40) k4_d = 13'd1638;
    dth_d = 15'(dth_b);
  end

  logic [12:0] k4_q;
  logic sgn_q, spin_q, sgn2_q, spin2_q, sgn3_q, spin3_q;
  logic signed [14:0] dth_q, dth2_q;
  logic [17:0] de_q;
  logic signed [14:0] dmp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      k4_q   <= k4_d;
      sgn_q  <= sgn_d;
      spin_q <= spin_d;
      dth_q  <= dth_d;
      de_q   <= de16;
      dmp_q  <= g16.damping;
    end
  end

  // Stage 19: sigmoid and gain x factor.
  logic [19:0] t3;
  logic [16:0] sa, sb, sig;
  logic signed [19:0] lin_op_d;
  logic [27:0] agk_d;
  logic signed [19:0] lin_op_q;
  logic [27:0] agk_q;
  always_comb begin
    t3 = 20'(de_q) * 20'd3;
    sa = ddgtp_pkg::sig_lut(5'(t3[19:11] > 9'd16 ? 9'd16 : t3[19:11]));
    sb = ddgtp_pkg::sig_lut(5'(t3[19:11] >= 9'd15 ? 9'd16 : t3[19:11] + 9'd1));
    if (t3[19:11] >= 9'd16) sig = ddgtp_pkg::sig_lut(5'd16);
    else sig = sa + 17'((28'(sb - sa) * 28'(t3[10:0]) + 28'd1024) >> 11);
    lin_op_d = $signed({3'b000, sig}) - (20'(dmp_q) <<< 4);
    agk_d    = 28'(ang_gain) * 28'(k4_q);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_op_q <= lin_op_d;
      agk_q    <= agk_d;
      sgn2_q   <= sgn_q;
      spin2_q  <= spin_q;
      dth2_q   <= dth_q;
    end
  end

  // Stage 20: products (Q.38 without the 2^9 for lin: handled as shift).
  logic signed [34:0] lin_p_q;
  logic signed [44:0] turn_p_q;
  logic signed [29:0] spin_p_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_p_q  <= 35'(lin_op_q * $signed({1'b0, lin_gain}));
      turn_p_q <= 45'($signed({1'b0, agk_q}) * dth2_q);
      spin_p_q <= 30'($signed({1'b0, ang_gain}) * dth2_q);
      sgn3_q   <= sgn2_q;
      spin3_q  <= spin2_q;
    end
  end

  // Stage 21: combine, round and saturate; reverse flips the sign, spin overrides.
  logic signed [46:0] lin_w, l_s, r_s;
  logic signed [21:0] l_r, r_r;
  logic signed [17:0] v;
  logic signed [15:0] ls_d, rs_d, ls_q, rs_q;
  always_comb begin
    lin_w = 47'(lin_p_q) <<< 9;
    l_s = lin_w - 47'(turn_p_q);
    r_s = lin_w + 47'(turn_p_q);
    if (sgn3_q) begin
      l_s = -l_s;
      r_s = -r_s;
    end
    l_r = 22'((l_s + 47'sd16777216) >>> 25);
    r_r = 22'((r_s + 47'sd16777216) >>> 25);
    v   = 18'((31'(spin_p_q) + 31'sd4096) >>> 13);
    if (spin3_q) begin
      l_r = -22'(v);
      r_r = 22'(v);
    end
    ls_d = l_r > 22'sd32767 ? 16'sd32767 : (l_r < -22'sd32768 ? -16'sd32768 : 16'(l_r));
    rs_d = r_r > 22'sd32767 ? 16'sd32767 : (r_r < -22'sd32768 ? -16'sd32768 : 16'(r_r));
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ls_q <= ls_d;
      rs_q <= rs_d;
    end
  end

  assign out_valid_o   = vld_q[Depth-1];
  assign left_speed_o  = ls_q;
  assign right_speed_o = rs_q;

endmodule

// ===== rtl/ddgtp_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// ddgtp_cordic_stage
// One registered CORDIC vectoring micro-rotation step.
// ----------------------------------------------------------------------------
module ddgtp_cordic_stage (
  input  logic              clk_i,
  input  logic [3:0]        step_i,
  input  logic              en_i,
  input  ddgtp_pkg::rot_t   rot_i,
  output ddgtp_pkg::rot_t   rot_o
);

  ddgtp_pkg::rot_t rot_d, rot_q;

  always_comb begin
    rot_d = rot_i;
    if (rot_i.y > 28'sd0) begin
      rot_d.x = rot_i.x + (rot_i.y >>> step_i);
      rot_d.y = rot_i.y - (rot_i.x >>> step_i);
      rot_d.z = rot_i.z + ddgtp_pkg::atan_lut(step_i);
    end else begin
      rot_d.x = rot_i.x - (rot_i.y >>> step_i);
      rot_d.y = rot_i.y + (rot_i.x >>> step_i);
      rot_d.z = rot_i.z - ddgtp_pkg::atan_lut(step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== rtl/ddgtp_isqrt_stage.sv =====
// ----------------------------------------------------------------------------
// ddgtp_isqrt_stage
// Two registered bits of a restoring integer square root.
// ----------------------------------------------------------------------------
module ddgtp_isqrt_stage (
  input  logic        clk_i,
  input  logic [4:0]  pos_i,
  input  logic        en_i,
  input  logic [34:0] rem_i,
  input  logic [17:0] root_i,
  output logic [34:0] rem_o,
  output logic [17:0] root_o
);

  logic [34:0] rem_d, rem_q, rem_a, rem_b;
  logic [17:0] root_d, root_q, root_a;

  always_comb begin
    rem_a  = rem_i;
    root_a = root_i;
    rem_b  = (35'(root_a) << (pos_i + 5'd1)) | (35'd1 << {pos_i, 1'b0});
    if (rem_a >= rem_b) begin
      rem_a  = rem_a - rem_b;
      root_a = root_a | (18'd1 << pos_i);
    end
    rem_d  = rem_a;
    root_d = root_a;
    rem_b  = '0;
    if (pos_i != 5'd0) begin
      rem_b = (35'(root_d) << pos_i) | (35'd1 << {pos_i - 5'd1, 1'b0});
      if (rem_d >= rem_b) begin
        rem_d  = rem_d - rem_b;
        root_d = root_d | (18'd1 << (pos_i - 5'd1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== rtl/ddgtp_regs.sv =====
// ----------------------------------------------------------------------------
// ddgtp_regs
// APB register file for the linear and angular gains.
// ----------------------------------------------------------------------------
module ddgtp_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [14:0] lin_gain_o,
  output logic [14:0] ang_gain_o
);

  logic [14:0] lin_q, ang_q;
  logic        wr;
  ddgtp_pkg::reg_idx_e idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = ddgtp_pkg::reg_idx_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= ddgtp_pkg::LinGainRst;
      ang_q <= ddgtp_pkg::AngGainRst;
    end else if (wr) begin
      unique case (idx)
        ddgtp_pkg::REG_LIN_GAIN: lin_q <= pwdata[14:0];
        ddgtp_pkg::REG_ANG_GAIN: ang_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ddgtp_pkg::REG_LIN_GAIN: prdata = {17'd0, lin_q};
      ddgtp_pkg::REG_ANG_GAIN: prdata = {17'd0, ang_q};
      default: prdata = 32'd0;
    endcase
  end

  assign lin_gain_o = lin_q;
  assign ang_gain_o = ang_q;

endmodule

// ===== rtl/ddgtp_checker.sv =====
// ----------------------------------------------------------------------------
// ddgtp_checker
// Port-level checks of the go-to-point pipeline.
// ----------------------------------------------------------------------------
module ddgtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        pready,
  input logic [15:0] left_speed_o,
  input logic [15:0] right_speed_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_speed_o)
      && $stable(right_speed_o)) else $error("stalled beat changed");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o) else $error("stall with empty output");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i) else $error("stall without back pressure");

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");

endmodule

bind diff_drive_go_to_point_top ddgtp_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .pready, .left_speed_o, .right_speed_o
);

// ===== tb/sv/diff_drive_go_to_point_top_tb.sv =====
// ----------------------------------------------------------------------------
// diff_drive_go_to_point_top_tb
// Drives poses with random bursts and output stalls, predicts wheel speeds in
// a local fixed-point model, and checks every result beat in order.
// ----------------------------------------------------------------------------
module diff_drive_go_to_point_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } wheel_pair_t;

  class wheel_scoreboard;
    logic [14:0] lin_gain;
    logic [14:0] ang_gain;
    wheel_pair_t pending[$];
    int errors;

    function new();
      lin_gain = ddgtp_pkg::LinGainRst;
      ang_gain = ddgtp_pkg::AngGainRst;
      errors = 0;
    endfunction

    function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function longint root(longint n);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 40;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - r - b;
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function longint atan_step(int i);
      longint t[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
      return t[i];
    endfunction

    function longint heading_to(longint dx, longint dy);
      longint x, y, z, nx;
      if (dx == 0 && dy == 0) return 0;
      if (dx == 0) return dy > 0 ? 12868 : -12868;
      if (dy == 0) return dx > 0 ? 0 : 25736;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? 205887 : -205887;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          nx = x + shr(y, i);
          y = y - shr(x, i);
          z += atan_step(i);
        end else begin
          nx = x - shr(y, i);
          y = y + shr(x, i);
          z -= atan_step(i);
        end
        x = nx;
      end
      z = shr(z + 4, 3);
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return z;
    endfunction

    function longint sigmoid3(longint de);
      longint s[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
                        64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
                        65514};
      longint t, idx;
      t = 3 * de;
      idx = t >>> 11;
      if (idx >= 16) return s[16];
      return s[idx] + (((s[idx + 1] - s[idx]) * (t & 2047) + 1024) >>> 11);
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] hd, logic signed [15:0] gx,
                            logic signed [15:0] gy, logic signed [14:0] dmp);
      longint dx, dy, de, dth, k4, sgn, l, r, ag, adth, v, lin, turn;
      wheel_pair_t w;
      dx = longint'(gx) - longint'(px);
      dy = longint'(gy) - longint'(py);
      de = root(dx * dx + dy * dy);
      dth = heading_to(dx, dy) - longint'(hd);
      ag = longint'(ang_gain);
      sgn = 1;
      while (dth > 25736) dth -= 51472;
      while (dth < -25736) dth += 51472;
      if (de > 4096) k4 = 3095;
      else if (de > 2048) k4 = 3459;
      else if (de > 1228) k4 = 3823;
      else if (de > 819) k4 = 4187;
      else k4 = 4551;
      if (dth > 13582) begin
        dth -= 25736;
        sgn = -1;
      end else if (dth < -13582) begin
        dth += 25736;
        sgn = -1;
      end
      adth = dth < 0 ? -dth : dth;
      if (adth > 12153) begin
        v = shr(ag * dth + 4096, 13);
        l = -v;
        r = v;
      end else begin
        if (de < 20480 && adth <= 5719) k4 = 1638;
        lin = longint'(lin_gain) * (sigmoid3(de) - longint'(dmp) * 16) * 512;
        turn = ag * k4 * dth;
        l = shr(sgn * (lin - turn) + (64'sd1 <<< 24), 25);
        r = shr(sgn * (lin + turn) + (64'sd1 <<< 24), 25);
      end
      w.left_speed = 16'(clamp16(l));
      w.right_speed = 16'(clamp16(r));
      pending.push_back(w);
    endfunction

    function void check_speeds(logic signed [15:0] ls, logic signed [15:0] rs);
      wheel_pair_t w;
      if (pending.size() == 0) begin
        $error("unexpected beat left=%0d right=%0d", ls, rs);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (ls !== w.left_speed) begin
        $error("left_speed expected %0d actual %0d", w.left_speed, ls);
        errors++;
      end
      if (rs !== w.right_speed) begin
        $error("right_speed expected %0d actual %0d", w.right_speed, rs);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [15:0] pos_x_i, pos_y_i, heading_i, goal_x_i, goal_y_i;
  logic signed [14:0] damping_i;
  logic signed [15:0] left_speed_o, right_speed_o;

  wheel_scoreboard sb;
  bit stall_hold;
  bit stim_done;

  diff_drive_go_to_point_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(ddgtp_pkg::reg_idx_e idx, logic [14:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx) << 2;
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ddgtp_pkg::REG_LIN_GAIN) sb.lin_gain = val;
    else sb.ang_gain = val;
  endtask

  task automatic send_pose(int px, int py, int hd, int gx, int gy, int dmp);
    in_valid_i <= 1'b1;
    pos_x_i <= 16'(px);
    pos_y_i <= 16'(py);
    heading_i <= 16'(hd);
    goal_x_i <= 16'(gx);
    goal_y_i <= 16'(gy);
    damping_i <= 15'(dmp);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pose(16'(px), 16'(py), 16'(hd), 16'(gx), 16'(gy), 15'(dmp));
  endtask

  task automatic idle_in(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic random_pose();
    logic signed [15:0] px, py, gx, gy, hd;
    logic signed [14:0] dmp;
    int m;
    m = $urandom_range(0, 9);
    px = 16'($urandom);
    py = 16'($urandom);
    hd = 16'($urandom_range(0, 51472) - 25736);
    dmp = 15'($urandom_range(0, 16384) - 8192);
    if (m < 4) begin
      gx = px + $signed(16'($urandom_range(0, 16000) - 8000));
      gy = py + $signed(16'($urandom_range(0, 16000) - 8000));
    end else if (m == 4) begin
      gx = px + $signed(16'($urandom_range(0, 40) - 20));
      gy = py + $signed(16'($urandom_range(0, 40) - 20));
    end else if (m == 5) begin
      gx = $urandom_range(0, 1) ? px : 16'($urandom);
      gy = (gx == px) ? 16'($urandom) : py;
    end else begin
      gx = 16'($urandom);
      gy = 16'($urandom);
    end
    if (m == 9) begin
      hd = 16'($urandom);
      dmp = 15'($urandom);
    end
    send_pose(px, py, hd, gx, gy, dmp);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_speeds(left_speed_o, right_speed_o);
  end

  initial begin
    int mode;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_hold) out_stall_i <= 1'b1;
      else begin
        mode = $urandom_range(0, 3);
        if (mode == 0) out_stall_i <= 1'b0;
        else out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    logic [14:0] lg[4] = '{15'd0, 15'd32767, 15'd8192, 15'd4096};
    logic [14:0] ag[4] = '{15'd32767, 15'd0, 15'd819, 15'd2000};
    sb = new();
    stall_hold = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    heading_i = '0;
    goal_x_i = '0;
    goal_y_i = '0;
    damping_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pose(0, 0, 0, 0, 0, 0);
    send_pose(0, 0, 0, 4096, 0, 0);
    send_pose(0, 0, 0, -4096, 0, 0);
    send_pose(0, 0, 0, 0, 4096, 0);
    send_pose(0, 0, 0, 0, -4096, 0);
    send_pose(-32768, -32768, 25736, 32767, 32767, -8192);
    send_pose(32767, 32767, -25736, -32768, -32768, 8192);
    send_pose(0, 0, 32767, 1000, 1000, 8191);
    send_pose(0, 0, -32768, -1000, 1000, -16384);
    send_pose(0, 0, 12000, 4096, 0, 0);
    send_pose(0, 0, -14000, 4096, 0, 0);
    send_pose(0, 0, 20000, 4096, 0, 0);
    send_pose(0, 0, 5000, 1000, 0, 100);
    send_pose(0, 0, 0, 500, 500, -8192);
    send_pose(0, 0, 0, 30000, 100, 8192);
    send_pose(100, 200, -3000, 2000, -1500, 0);
    idle_in(1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(ddgtp_pkg::REG_LIN_GAIN, lg[ph - 1]);
        write_reg(ddgtp_pkg::REG_ANG_GAIN, ag[ph - 1]);
      end
      for (int n = 0; n < 390; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 390; b++, n++) begin
          if (ph == 2 && n == 100) stall_hold = 1'b1;
          if (ph == 2 && n == 160) stall_hold = 1'b0;
          random_pose();
        end
        if ($urandom_range(0, 2) != 0) idle_in($urandom_range(1, 6));
      end
      idle_in(1);
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (stall_hold) begin
        held++;
        if (held > 80) stall_hold = 1'b0;
      end else held = 0;
      if (stim_done) begin
        if (sb.errors == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
      end
    end
  end
endmodule

// ===== diff_drive_go_to_point_top.f =====
rtl/ddgtp_pkg.sv
rtl/ddgtp_cordic_stage.sv
rtl/ddgtp_isqrt_stage.sv
rtl/ddgtp_regs.sv
rtl/diff_drive_go_to_point_top.sv
rtl/ddgtp_checker.sv
tb/sv/diff_drive_go_to_point_top_tb.sv
